/* src/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg: shared definitions for the band-limited spectral flux block
// Sizes, register codes and the job record passed from front to back end.
// ----------------------------------------------------------------------------
package sfb_pkg;

  // Frame store and amplitude sizes
  localparam int unsigned MAX_BINS  = 512;
  localparam int unsigned AMP_WIDTH = 16;
  localparam int unsigned POS_W     = $clog2(MAX_BINS);
  localparam int unsigned FILL_W    = POS_W + 1;

  // Register field widths
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned FIRST_W    = 9;
  localparam int unsigned END_W      = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;

  // Datapath widths
  localparam int unsigned SQ_W    = 2 * AMP_WIDTH;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned FLUX_W  = SUM_W / 2;
  localparam int unsigned REM_W   = FLUX_W + 3;

  // Square root iteration count, one result bit per step
  localparam int unsigned SQRT_STEPS = FLUX_W;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_COUNT = 2'd0,
    REG_FIRST_BIN = 2'd1,
    REG_END_BIN   = 2'd2
  } cfg_reg_e;

  // One classified bin: magnitude of the difference plus its role in the frame
  typedef struct packed {
    logic [AMP_WIDTH-1:0] diff;
    logic                 in_band;
    logic                 last;
  } sfb_job_t;

endpackage

/* src/sfb_if.sv */
// ----------------------------------------------------------------------------
// sfb_if: valid/ready channels of the spectral flux block
// Amplitude input channel and flux result channel.
// ----------------------------------------------------------------------------
interface sfb_amp_if;
  import sfb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AMP_WIDTH-1:0] amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink   (input valid, input amplitude, output ready);
endinterface

interface sfb_flux_if;
  import sfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLUX_W-1:0] flux_value;

  modport source (output valid, output flux_value, input ready);
  modport sink   (input valid, input flux_value, output ready);
endinterface

/* src/sfb_ram.sv */
// ----------------------------------------------------------------------------
// sfb_ram: generic single-write, single-read RAM
// Registered read port; a read and write to the same address return old data.
// ----------------------------------------------------------------------------
module sfb_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 512,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with read-first registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sfb_front.sv */
// ----------------------------------------------------------------------------
// sfb_front: bin intake and classification
// Holds the registers, tracks the bin position, swaps the frame store entry
// and hands |current - previous| with band/last flags to the queue.
// ----------------------------------------------------------------------------
module sfb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfb_amp_if.sink                        amp_i,
  output logic                           job_valid_o,
  output sfb_pkg::sfb_job_t              job_o,
  input  logic                           job_ready_i
);
  import sfb_pkg::*;

  logic [CNT_W-1:0]     bin_count_q;
  logic [FIRST_W-1:0]   first_bin_q;
  logic [END_W-1:0]     end_bin_q;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [FILL_W-1:0]    fill_q, fill_d;

  logic [CNT_W-1:0]     size;
  logic [CNT_W-1:0]     first_p1;
  logic [CNT_W-1:0]     band_end;
  logic [CNT_W-1:0]     clip_end;
  logic [CNT_W-1:0]     pos_ext;
  logic                 write_hit;
  logic                 in_band;
  logic                 last;
  logic                 accept;

  logic                 s1_valid_q;
  logic [AMP_WIDTH-1:0] s1_amp_q;
  logic                 s1_band_q;
  logic                 s1_last_q;
  logic                 s1_known_q;
  logic [AMP_WIDTH-1:0] rdata;
  logic [AMP_WIDTH-1:0] prev_amp;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= CNT_W'(MAX_BINS);
      first_bin_q <= '0;
      end_bin_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BIN_COUNT: bin_count_q <= cfg_data_i[CNT_W-1:0];
        REG_FIRST_BIN: first_bin_q <= cfg_data_i[FIRST_W-1:0];
        REG_END_BIN:   end_bin_q   <= cfg_data_i[END_W-1:0];
        default:       ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, clamp to the store depth
  always_comb begin
    if (bin_count_q == '0) begin
      size = CNT_W'(1);
    end else if (bin_count_q > CNT_W'(MAX_BINS)) begin
      size = CNT_W'(MAX_BINS);
    end else begin
      size = bin_count_q;
    end
  end

  // Band end: frame end, or end_bin clipped to the frame, at least first+1
  assign first_p1 = CNT_W'(first_bin_q) + CNT_W'(1);
  assign clip_end = (end_bin_q < size) ? end_bin_q : size;

  always_comb begin
    if (end_bin_q == '0) begin
      band_end = size;
    end else if (clip_end < first_p1) begin
      band_end = first_p1;
    end else begin
      band_end = clip_end;
    end
  end

  // Classification of the bin at the current position
  assign pos_ext   = CNT_W'(pos_q);
  assign write_hit = pos_ext < size;
  assign in_band   = write_hit && (pos_q >= first_bin_q) && (pos_ext < band_end);
  assign last      = (pos_ext + CNT_W'(1)) >= size;

  assign amp_i.ready = !s1_valid_q || job_ready_i;
  assign accept      = amp_i.valid && amp_i.ready;

  // Position wraps at the frame's last bin; the fill mark grows with new entries
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + POS_W'(1);
      if (write_hit && (CNT_W'(pos_q) == CNT_W'(fill_q))) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  // Previous-frame store: read old entry and write the new one in the same cycle
  sfb_ram #(
    .WIDTH (AMP_WIDTH),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && write_hit),
    .waddr_i (pos_q),
    .wdata_i (amp_i.amplitude),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // Stage register waiting on the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_amp_q   <= '0;
      s1_band_q  <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_known_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_amp_q   <= amp_i.amplitude;
      s1_band_q  <= in_band;
      s1_last_q  <= last;
      s1_known_q <= CNT_W'(pos_q) < CNT_W'(fill_q);
    end else if (job_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Entries never written since reset read as zero
  assign prev_amp = s1_known_q ? rdata : '0;

  assign job_valid_o    = s1_valid_q;
  assign job_o.diff     = (s1_amp_q >= prev_amp) ? (s1_amp_q - prev_amp)
                                                 : (prev_amp - s1_amp_q);
  assign job_o.in_band  = s1_band_q;
  assign job_o.last     = s1_last_q;

endmodule

/* src/sfb_queue.sv */
// ----------------------------------------------------------------------------
// sfb_queue: short job queue between front and back end
// Register-based FIFO of classified bins.
// ----------------------------------------------------------------------------
module sfb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfb_pkg::sfb_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output sfb_pkg::sfb_job_t pop_data_o,
  output logic              empty_o
);
  import sfb_pkg::*;

  sfb_job_t               entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

  assign pop_data_o = entries_q[rd_ptr_q];

endmodule

/* src/sfb_back.sv */
// ----------------------------------------------------------------------------
// sfb_back: squaring and frame accumulation
// Squares in-band differences, sums them over the frame and hands the total
// to the square root unit at the frame's last bin.
// ----------------------------------------------------------------------------
module sfb_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  sfb_pkg::sfb_job_t         job_i,
  output logic                      job_ready_o,
  output logic                      root_start_o,
  output logic [sfb_pkg::SUM_W-1:0] root_value_o,
  input  logic                      root_ready_i
);
  import sfb_pkg::*;

  logic             a_valid_q;
  logic [SQ_W-1:0]  a_sq_q;
  logic             a_last_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_total;
  logic             a_move;
  logic             job_take;

  // Stage moves on unless a frame end waits for the root unit
  assign a_move      = a_valid_q && (!a_last_q || root_ready_i);
  assign job_ready_o = !a_valid_q || a_move;
  assign job_take    = job_valid_i && job_ready_o;

  // Square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_sq_q    <= '0;
      a_last_q  <= 1'b0;
    end else if (job_take) begin
      a_valid_q <= 1'b1;
      a_sq_q    <= job_i.in_band ? SQ_W'(job_i.diff) * SQ_W'(job_i.diff) : '0;
      a_last_q  <= job_i.last;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  // Frame accumulator; cleared as the total leaves
  assign sum_total = sum_q + SUM_W'(a_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (a_move) begin
      sum_q <= a_last_q ? '0 : sum_total;
    end
  end

  assign root_start_o = a_move && a_last_q;
  assign root_value_o = sum_total;

endmodule

/* src/sfb_sqrt.sv */
// ----------------------------------------------------------------------------
// sfb_sqrt: iterative floor square root and output register
// Digit-by-digit root, one result bit per cycle, feeding the result channel.
// ----------------------------------------------------------------------------
module sfb_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sfb_pkg::SUM_W-1:0] value_i,
  output logic                      ready_o,
  sfb_flux_if.source                flux_o
);
  import sfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [SUM_W-1:0]      val_q;
  logic [REM_W-1:0]      rem_q;
  logic [FLUX_W-1:0]     root_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic                  out_valid_q;
  logic [FLUX_W-1:0]     out_data_q;

  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;
  logic [REM_W-1:0]      rem_next;
  logic [FLUX_W-1:0]     root_next;
  logic                  out_free;
  logic                  out_load;
  logic [FLUX_W-1:0]     out_next;

  // One root bit: bring down two value bits, try (4*root + 1)
  assign rem_sh    = {rem_q[REM_W-3:0], val_q[SUM_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fits      = rem_sh >= trial;
  assign rem_next  = fits ? (rem_sh - trial) : rem_sh;
  assign root_next = {root_q[FLUX_W-2:0], fits};

  assign out_free = !out_valid_q || flux_o.ready;
  assign ready_o  = state_q == ST_IDLE;

  // Result register loads at the last root step or from the waiting state
  assign out_load = out_free && (((state_q == ST_BUSY) && (cnt_q == '0)) ||
                                 (state_q == ST_DONE));
  assign out_next = (state_q == ST_DONE) ? root_q : root_next;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      val_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_data_q  <= out_next;
        out_valid_q <= 1'b1;
      end else if (flux_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            val_q   <= value_i;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= SQRT_CNT_W'(SQRT_STEPS - 1);
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          val_q  <= {val_q[SUM_W-3:0], 2'b00};
          rem_q  <= rem_next;
          root_q <= root_next;
          if (cnt_q == '0) begin
            state_q <= out_free ? ST_IDLE : ST_DONE;
          end else begin
            cnt_q <= cnt_q - SQRT_CNT_W'(1);
          end
        end
        ST_DONE: begin
          // Result waits for the output register to drain
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign flux_o.valid      = out_valid_q;
  assign flux_o.flux_value = out_data_q;

endmodule

/* src/spectral_flux_band.sv */
// ----------------------------------------------------------------------------
// spectral_flux_band: band-limited L2 spectral flux over amplitude bins
//
// Usage:
//   amp_i carries one 16-bit amplitude bin per transfer, bins in ascending
//   order, frame after frame. flux_o carries one 21-bit result per frame:
//   the floor square root of the summed squared bin differences against the
//   previous frame, over the band first_bin .. end bound.
//   Registers (bin_count, first_bin, end_bin) are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while the block is idle.
// Throughput: one bin per cycle unless a full queue holds the input back. The
//   square root unit takes a load plus 21 root steps per frame.
// Result path: the frame's last bin passes the store read, the queue, the square
//   stage and the accumulation, then 21 root steps into the output register.
// Reset: registers return to 512/0/0 and the previous frame reads as zero;
//   a fill mark over the store replaces any clearing pass, so bins are taken
//   right after reset.
// Stalls: a held result sits in the output register while the root unit and
//   a four-entry queue keep absorbing bins; input stalls only once those fill.
// ----------------------------------------------------------------------------
module spectral_flux_band (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfb_amp_if.sink                        amp_i,
  sfb_flux_if.source                     flux_o
);
  import sfb_pkg::*;

  logic             front_valid;
  sfb_job_t         front_job;
  logic             queue_full;
  sfb_job_t         queue_job;
  logic             queue_empty;
  logic             back_ready;
  logic             root_start;
  logic [SUM_W-1:0] root_value;
  logic             root_ready;

  // Intake and classification
  sfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .amp_i       (amp_i),
    .job_valid_o (front_valid),
    .job_o       (front_job),
    .job_ready_i (!queue_full)
  );

  // Decoupling queue
  sfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (back_ready),
    .pop_data_o  (queue_job),
    .empty_o     (queue_empty)
  );

  // Square and accumulate
  sfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!queue_empty),
    .job_i        (queue_job),
    .job_ready_o  (back_ready),
    .root_start_o (root_start),
    .root_value_o (root_value),
    .root_ready_i (root_ready)
  );

  // Square root and result register
  sfb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (root_value),
    .ready_o (root_ready),
    .flux_o  (flux_o)
  );

endmodule

/* verif/sfb_flux_checker.sv */
// ----------------------------------------------------------------------------
// sfb_flux_checker: flux prediction and result checking
// Watches the register port and both channels of spectral_flux_band. It
// keeps its own copy of the registers, the previous frame and the running
// sum, predicts one flux value per completed frame and compares each flux
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module sfb_flux_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfb_amp_if                             amp_i,
  sfb_flux_if                            flux_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import sfb_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow registers
  logic [CNT_W-1:0]   frame_bins;
  logic [FIRST_W-1:0] band_lo;
  logic [END_W-1:0]   band_hi;

  // Shadow state
  logic [AMP_WIDTH-1:0] prior_frame [MAX_BINS];
  int unsigned          bin_pos;
  logic [SUM_W-1:0]     sq_acc;
  logic [FLUX_W-1:0]    flux_due [$];

  // Floor square root, one result bit at a time from the top
  function automatic logic [FLUX_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [FLUX_W-1:0] root;
    logic [FLUX_W-1:0] trial;
    logic [SUM_W-1:0]  wide;
    root = '0;
    for (int b = FLUX_W - 1; b >= 0; b--) begin
      trial    = root;
      trial[b] = 1'b1;
      wide     = SUM_W'(trial);
      if (wide * wide <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted bin into the frame; queue a flux value at frame end
  function automatic void absorb_bin(input logic [AMP_WIDTH-1:0] amp);
    int unsigned      span;
    int unsigned      stop;
    logic [AMP_WIDTH-1:0] delta;
    logic [SUM_W-1:0] wide;
    span = (frame_bins == 0) ? 1 : (frame_bins > MAX_BINS) ? MAX_BINS : frame_bins;
    if (band_hi == 0) begin
      stop = span;
    end else begin
      stop = (band_hi < span) ? band_hi : span;
      if (stop < band_lo + 1) stop = band_lo + 1;
    end
    if (bin_pos < span) begin
      if (bin_pos >= band_lo && bin_pos < stop) begin
        delta  = (amp >= prior_frame[bin_pos]) ? amp - prior_frame[bin_pos]
                                               : prior_frame[bin_pos] - amp;
        wide   = SUM_W'(delta);
        sq_acc = sq_acc + wide * wide;
      end
      prior_frame[bin_pos] = amp;
    end
    // a shrunken frame size ends the frame at the current bin
    if (bin_pos + 1 >= span) begin
      flux_due.push_back(floor_root(sq_acc));
      sq_acc  = '0;
      bin_pos = 0;
    end else begin
      bin_pos = bin_pos + 1;
    end
  endfunction

  // Register writes, result compare, then prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bins = CNT_W'(MAX_BINS);
      band_lo    = '0;
      band_hi    = '0;
      for (int i = 0; i < MAX_BINS; i++) prior_frame[i] = '0;
      bin_pos      = 0;
      sq_acc       = '0;
      flux_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BIN_COUNT: frame_bins = cfg_data_i[CNT_W-1:0];
          REG_FIRST_BIN: band_lo    = cfg_data_i[FIRST_W-1:0];
          REG_END_BIN:   band_hi    = cfg_data_i[END_W-1:0];
          default: ;
        endcase
      end
      if (flux_i.valid && flux_i.ready) begin
        if (flux_due.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("%0t: flux transfer with none expected, got %0d",
                     $realtime, flux_i.flux_value);
          fail_count_o++;
        end else begin
          if (flux_i.flux_value !== flux_due[0]) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("%0t: flux_value mismatch, expected %0d, got %0d",
                       $realtime, flux_due[0], flux_i.flux_value);
            fail_count_o++;
          end
          void'(flux_due.pop_front());
        end
      end
      if (amp_i.valid && amp_i.ready) absorb_bin(amp_i.amplitude);
      pending_o = flux_due.size();
    end
  end

endmodule

/* verif/spectral_flux_band_test.sv */
// ----------------------------------------------------------------------------
// spectral_flux_band_test: testbench top for spectral_flux_band
// Drives amplitude bins and register writes, stalls the flux receiver at
// random and leaves prediction and checking to sfb_flux_checker. A short
// directed part covers extreme amplitudes, reset settings, size changes in
// mid-frame and odd band bounds; random segments follow, each with its own
// register setting, a few whole frames and now and then a partial one.
// ----------------------------------------------------------------------------
module spectral_flux_band_test;
  import sfb_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_BINS  = 1550;
  localparam int unsigned LARGE_FRAMES = 3;
  localparam int unsigned TIMEOUT      = 4_000_000;

  typedef enum int unsigned {AMP_EXTREME, AMP_LOW, AMP_FULL} amp_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned flux_pending;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned bins_sent;

  sfb_amp_if  amp_ch ();
  sfb_flux_if flux_ch ();

  spectral_flux_band uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .amp_i      (amp_ch),
    .flux_o     (flux_ch)
  );

  sfb_flux_checker u_flux_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .amp_i        (amp_ch),
    .flux_i       (flux_ch),
    .fail_count_o (fail_count),
    .pending_o    (flux_pending)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Run limit
  initial begin
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

  // Flux receiver: random stalls, decided at each falling edge
  initial begin
    flux_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      flux_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // One bin transfer, with random gaps ahead of it
  task automatic push_bin(input logic [AMP_WIDTH-1:0] amp);
    while ($urandom_range(99) < src_gap_pct) begin
      amp_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    amp_ch.valid     <= 1'b1;
    amp_ch.amplitude <= amp;
    @(posedge clk_i);
    while (!amp_ch.ready) @(posedge clk_i);
    bins_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending, collect every outstanding flux value, let bins drain
  task automatic settle();
    amp_ch.valid <= 1'b0;
    while (flux_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(input int unsigned count, input int unsigned lo,
                            input int unsigned hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BIN_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(negedge clk_i);
    cfg_idx_i  <= REG_FIRST_BIN;
    cfg_data_i <= CFG_DATA_W'(lo);
    @(negedge clk_i);
    cfg_idx_i  <= REG_END_BIN;
    cfg_data_i <= CFG_DATA_W'(hi);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [AMP_WIDTH-1:0] pick_amp(input amp_style_e style);
    case (style)
      AMP_EXTREME: return ($urandom_range(1) != 0) ? '1 : '0;
      AMP_LOW:     return AMP_WIDTH'($urandom_range(255));
      default:     return AMP_WIDTH'($urandom());
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned dir_bins;
    int unsigned done;
    int unsigned seg;
    int unsigned large_left;
    int unsigned roll;
    int unsigned count;
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned frames;
    int unsigned n;
    amp_style_e  style;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_BIN_COUNT;
    cfg_data_i       <= '0;
    amp_ch.valid     <= 1'b0;
    amp_ch.amplitude <= '0;
    src_gap_pct    = 25;
    sink_stall_pct = 55;
    bins_sent      = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, then the frame shrinks under the current position
    push_bin('1);
    push_bin('0);
    push_bin(16'h8001);
    settle();
    write_regs(3, 0, 0);
    push_bin(16'h1234);
    // full frame against the stored one
    push_bin('1);
    push_bin('1);
    push_bin('0);
    settle();
    // zero frame size acts as one bin per frame
    write_regs(0, 0, 0);
    push_bin('1);
    push_bin('0);
    settle();
    // band starts past the frame end
    write_regs(3, 5, 0);
    push_bin(16'hA5A5);
    push_bin(16'h5A5A);
    push_bin('1);
    settle();
    // end bound below first_bin is raised to first_bin + 1
    write_regs(6, 3, 2);
    repeat (3) begin
      push_bin('1);
      push_bin('0);
    end
    settle();
    // end bound past the frame end is clipped
    write_regs(4, 1, 1023);
    push_bin('0);
    push_bin('1);
    push_bin(16'h0001);
    push_bin(16'hFFFE);
    settle();
    write_regs(2, 0, 1);
    push_bin('1);
    push_bin('1);
    dir_bins = bins_sent;

    // random segments
    seg        = 0;
    large_left = LARGE_FRAMES;
    while (bins_sent < dir_bins + RANDOM_BINS) begin
      done = bins_sent - dir_bins;
      if (done < RANDOM_BINS / 3) begin
        src_gap_pct    = 25;
        sink_stall_pct = 55;
      end else if (done < 2 * RANDOM_BINS / 3) begin
        src_gap_pct    = 55;
        sink_stall_pct = 25;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      settle();

      // frame size: mostly small, a few of the largest while there is room
      if (large_left != 0 && done + MAX_BINS <= RANDOM_BINS &&
          (seg == 2 || $urandom_range(11) == 0)) begin
        large_left--;
        count  = (large_left == LARGE_FRAMES - 1) ? 1023 :
                 (large_left == 0) ? MAX_BINS : $urandom_range(513, 1022);
        frames = 1;
      end else begin
        roll   = $urandom_range(9);
        count  = (roll == 0) ? 0 : (roll == 1) ? 1 : $urandom_range(2, 40);
        frames = $urandom_range(1, 5);
      end
      span = (count == 0) ? 1 : (count > MAX_BINS) ? MAX_BINS : count;

      // band bounds, inside the frame most of the time
      roll = $urandom_range(9);
      lo   = (roll < 4) ? 0 : (roll < 6) ? $urandom_range(511) :
             (roll == 6) ? 511 : $urandom_range(span - 1);
      roll = $urandom_range(9);
      hi   = (roll < 4) ? 0 : (roll == 4) ? 1023 :
             (roll == 5) ? $urandom_range(1023) : $urandom_range(1, span);
      write_regs(count, lo, hi);

      // whole frames, sometimes a trailing partial one
      n = frames * span;
      if (span > 1 && $urandom_range(5) == 0) n += $urandom_range(1, span - 1);
      style = amp_style_e'($urandom_range(2));
      repeat (n) push_bin(pick_amp(style));
      seg++;
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* spectral_flux_band.f */
src/sfb_pkg.sv
src/sfb_if.sv
src/sfb_ram.sv
src/sfb_front.sv
src/sfb_queue.sv
src/sfb_back.sv
src/sfb_sqrt.sv
src/spectral_flux_band.sv
verif/sfb_flux_checker.sv
verif/spectral_flux_band_test.sv
